FILE: sv/lphs_pkg.sv
// Shared constants and types for the linear probing hash set unit.
package lphs_pkg;

    localparam int MAX_SLOTS = 64;
    localparam int POS_W = $clog2(MAX_SLOTS);
    localparam int SIZE_W = $clog2(MAX_SLOTS + 1);
    localparam int KEY_W = 31;
    localparam int CNT_W = $clog2(KEY_W);
    localparam int TABLE_SIZE_W = 7;
    localparam logic [TABLE_SIZE_W-1:0] TABLE_SIZE_RESET = 7'd64;
    localparam int CFG_ADDR_W = 3;
    localparam logic REG_TABLE_SIZE = 1'b0;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    typedef enum logic [2:0] {
        ST_INSERTED = 3'd0,
        ST_PRESENT  = 3'd1,
        ST_FULL     = 3'd2,
        ST_FOUND    = 3'd3,
        ST_MISSING  = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_LOOK,
        S_CMP
    } state_t;

endpackage

FILE: sv/linear_probe_hash_set_unit.sv
// Linear probing hash set: key modulo unit, probe sequencer and slot key memory.
// Sequence: the request is registered on accept, S_DIV forms the key modulo table size by
// restoring division, then S_LOOK and S_CMP probe slot by slot until a match, an empty slot
// or a full pass; then the result beat. One item at a time, probes bounded by table size.
// Reset: all slot used bits clear at once (no clearing pass), table_size reads 64.
// Slot keys live in a single-port synchronous RAM and carry no reset.
module linear_probe_hash_set_unit
    import lphs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  opcode,
    input  logic [KEY_W-1:0]      key,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [2:0]            status
);

    state_t                  state_reg, state_next;
    logic [TABLE_SIZE_W-1:0] table_size_reg;
    logic [MAX_SLOTS-1:0]    used_reg, used_next;
    logic                    out_valid_reg, out_valid_next;
    status_t                 status_reg, status_next;
    logic                    op_reg, op_next;
    logic [KEY_W-1:0]        key_reg, key_next;
    logic [SIZE_W-1:0]       size_reg, size_next;
    logic [POS_W-1:0]        rem_reg, rem_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [POS_W-1:0]        pos_reg, pos_next;
    logic [SIZE_W-1:0]       probe_reg, probe_next;
    logic [KEY_W-1:0]        rd_reg;

    logic [KEY_W-1:0]        key_mem [MAX_SLOTS];
    logic                    mem_we;
    logic                    mem_re;

    logic [SIZE_W-1:0]       live_size;
    logic [SIZE_W-1:0]       div_try;
    logic [SIZE_W-1:0]       div_r;
    logic [SIZE_W-1:0]       size_last;
    logic                    can_emit;
    logic                    cfg_wr;

    // config port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_TABLE_SIZE);
    assign prdata = (paddr[2] == REG_TABLE_SIZE)
                  ? {{(32-TABLE_SIZE_W){1'b0}}, table_size_reg} : 32'd0;

    always_comb
    begin
        if (table_size_reg == '0)
            live_size = SIZE_W'(1);
        else if (SIZE_W'(table_size_reg) > SIZE_W'(MAX_SLOTS))
            live_size = SIZE_W'(MAX_SLOTS);
        else
            live_size = SIZE_W'(table_size_reg);
    end

    // one restoring step of key mod size
    assign div_try   = {rem_reg, key_reg[cnt_reg]};
    assign div_r     = (div_try >= size_reg) ? div_try - size_reg : div_try;
    assign size_last = size_reg - SIZE_W'(1);
    assign can_emit  = !out_valid_reg || !out_stall;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign status    = status_reg;

    always_comb
    begin
        state_next     = state_reg;
        used_next      = used_reg;
        out_valid_next = out_valid_reg && out_stall;
        status_next    = status_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        size_next      = size_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        pos_next       = pos_reg;
        probe_next     = probe_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = opcode;
                    key_next   = key;
                    size_next  = live_size;
                    rem_next   = '0;
                    cnt_next   = CNT_W'(KEY_W - 1);
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                rem_next = div_r[POS_W-1:0];
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    pos_next   = div_r[POS_W-1:0];
                    probe_next = '0;
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                if (!used_reg[pos_reg])
                begin
                    if (can_emit)
                    begin
                        if (op_reg == OP_INSERT)
                        begin
                            mem_we             = 1'b1;
                            used_next[pos_reg] = 1'b1;
                            status_next        = ST_INSERTED;
                        end
                        else
                            status_next = ST_MISSING;
                        out_valid_next = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
                else
                begin
                    mem_re     = 1'b1;
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (rd_reg == key_reg)
                begin
                    if (can_emit)
                    begin
                        status_next    = (op_reg == OP_INSERT) ? ST_PRESENT : ST_FOUND;
                        out_valid_next = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
                else if (probe_reg == size_last)
                begin
                    if (can_emit)
                    begin
                        status_next    = (op_reg == OP_INSERT) ? ST_FULL : ST_MISSING;
                        out_valid_next = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
                else
                begin
                    probe_next = probe_reg + SIZE_W'(1);
                    pos_next   = ({1'b0, pos_reg} == size_last) ? '0 : pos_reg + POS_W'(1);
                    state_next = S_LOOK;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            used_reg       <= '0;
            out_valid_reg  <= 1'b0;
            table_size_reg <= TABLE_SIZE_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr)
                table_size_reg <= pwdata[TABLE_SIZE_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        op_reg     <= op_next;
        key_reg    <= key_next;
        size_reg   <= size_next;
        rem_reg    <= rem_next;
        cnt_reg    <= cnt_next;
        pos_reg    <= pos_next;
        probe_reg  <= probe_next;
    end

    // slot key memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
            key_mem[pos_reg] <= key_reg;
        if (mem_re)
            rd_reg <= key_mem[pos_reg];
    end

endmodule

FILE: tb/tb_linear_probe_hash_set_unit.sv
// Testbench for linear_probe_hash_set_unit: directed and random set traffic checked by a probing model.
`timescale 1ns / 1ps

module tb_linear_probe_hash_set_unit
    import lphs_pkg::*;
;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_AT = 1200;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_ITEMS = 150;
    localparam int MAX_PRINTED = 100;
    localparam logic [CFG_ADDR_W-1:0] TABLE_SIZE_ADDR = CFG_ADDR_W'(4 * int'(REG_TABLE_SIZE));

    typedef struct {
        logic             op;
        logic [KEY_W-1:0] key;
    } set_req_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic                  opcode = OP_INSERT;
    logic [KEY_W-1:0]      key = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [2:0]            status;

    set_req_t                request_q[$];
    status_t                 status_due_q[$];
    logic [KEY_W-1:0]        stored_key_pool[$];

    logic [TABLE_SIZE_W-1:0] model_table_size = TABLE_SIZE_RESET;
    logic [KEY_W-1:0]        model_keys[MAX_SLOTS];
    logic                    model_used[MAX_SLOTS];

    int send_idle_pct = 35;
    int recv_idle_pct = 77;
    int items_queued = 0;
    int items_accepted = 0;
    int results_seen = 0;
    int fail_count = 0;
    int hold_left = 0;
    int idle_cycles = 0;
    int size_settings = 1;
    int status_hits[5] = '{default: 0};

    linear_probe_hash_set_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .opcode    (opcode),
        .key       (key),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned live_span(input logic [TABLE_SIZE_W-1:0] cfg);
        if (cfg == 0)
            return 1;
        if (cfg > MAX_SLOTS)
            return MAX_SLOTS;
        return cfg;
    endfunction

    function automatic status_t probe_model_status(input logic op, input logic [KEY_W-1:0] k);
        int unsigned span;
        int unsigned pos;
        status_t     st;
        span = live_span(model_table_size);
        pos = k % span;
        st = (op == OP_INSERT) ? ST_FULL : ST_MISSING;
        for (int unsigned probe = 0; probe < span; probe++)
        begin
            if (!model_used[pos])
            begin
                if (op == OP_INSERT)
                begin
                    model_used[pos] = 1'b1;
                    model_keys[pos] = k;
                    st = ST_INSERTED;
                end
                else
                    st = ST_MISSING;
                break;
            end
            if (model_keys[pos] == k)
            begin
                st = (op == OP_INSERT) ? ST_PRESENT : ST_FOUND;
                break;
            end
            pos = (pos + 1 >= span) ? 0 : pos + 1;
        end
        return st;
    endfunction

    task automatic report_mismatch(input string msg);
        fail_count++;
        if (fail_count <= MAX_PRINTED)
            $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin : drive_proc
        set_req_t nxt;
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && !in_stall)
            begin
                status_due_q.push_back(probe_model_status(opcode, key));
                items_accepted++;
            end
            if (!in_valid || !in_stall)
            begin
                if (request_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    nxt = request_q.pop_front();
                    in_valid <= 1'b1;
                    opcode <= nxt.op;
                    key <= nxt.key;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver and checker
    always @(posedge clk or negedge rst_n)
    begin : check_proc
        status_t want;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (status_due_q.size() == 0)
                    report_mismatch($sformatf("status beat %0d with nothing pending", status));
                else
                begin
                    want = status_due_q.pop_front();
                    status_hits[int'(want)]++;
                    if (status !== want)
                        report_mismatch($sformatf("status got %0d want %0d (%s)",
                                                  status, want, want.name()));
                end
                if (results_seen == HOLD_AT)
                    hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog: no beat for %0d cycles, %0d results pending",
                     idle_cycles, status_due_q.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic push_req(input logic op, input logic [KEY_W-1:0] k);
        set_req_t r;
        r.op = op;
        r.key = k;
        request_q.push_back(r);
        items_queued++;
        if (op == OP_INSERT)
            stored_key_pool.push_back(k);
    endtask

    task automatic wait_drained();
        while (results_seen < items_queued)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_table_size(input logic [TABLE_SIZE_W-1:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= TABLE_SIZE_ADDR;
        pwdata <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        model_table_size = value;
        size_settings++;
    endtask

    task automatic random_phase(input int count);
        int unsigned      span;
        int unsigned      base;
        int unsigned      home;
        int unsigned      q;
        int unsigned      sel;
        logic             op;
        logic [KEY_W-1:0] k;
        span = live_span(model_table_size);
        base = $urandom_range(0, span - 1);
        for (int i = 0; i < count; i++)
        begin
            op = ($urandom_range(0, 99) < 40) ? OP_INSERT : OP_LOOKUP;
            sel = $urandom_range(0, 99);
            if (sel < 45)
            begin
                home = (base + $urandom_range(0, 3)) % span;
                q = $urandom_range(0, (32'h7fff_ffff - span) / span);
                k = KEY_W'(q * span + home);
            end
            else if (sel < 80 && stored_key_pool.size() != 0)
                k = stored_key_pool[$urandom_range(0, stored_key_pool.size() - 1)];
            else
                k = KEY_W'($urandom());
            push_req(op, k);
        end
        wait_drained();
    endtask

    initial
    begin : stimulus
        logic [TABLE_SIZE_W-1:0] sizes[9];
        sizes = '{7'd5, 7'd12, 7'd20, 7'd0, 7'd33, 7'd48, 7'd127, 7'd64, 7'd9};
        for (int i = 0; i < MAX_SLOTS; i++)
        begin
            model_used[i] = 1'b0;
            model_keys[i] = '0;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset size, empty table, wrap-around probing
        push_req(OP_LOOKUP, 31'd0);
        push_req(OP_INSERT, 31'd0);
        push_req(OP_INSERT, 31'd0);
        push_req(OP_LOOKUP, 31'd0);
        push_req(OP_INSERT, 31'h7fff_ffff);
        push_req(OP_LOOKUP, 31'h7fff_ffff);
        push_req(OP_LOOKUP, 31'd64);
        push_req(OP_INSERT, 31'd64);
        push_req(OP_INSERT, 31'd128);
        push_req(OP_LOOKUP, 31'd128);
        push_req(OP_INSERT, 31'd127);
        push_req(OP_LOOKUP, 31'd127);
        push_req(OP_INSERT, 31'h2aaa_aaaa);
        push_req(OP_INSERT, 31'h5555_5555);
        wait_drained();

        write_table_size(7'd1);
        push_req(OP_INSERT, 31'd5);
        push_req(OP_LOOKUP, 31'd0);
        push_req(OP_LOOKUP, 31'd5);
        wait_drained();

        // size zero behaves as one slot
        write_table_size(7'd0);
        push_req(OP_INSERT, 31'h7fff_ffff);
        push_req(OP_LOOKUP, 31'd0);
        wait_drained();

        write_table_size(7'd2);
        push_req(OP_INSERT, 31'd3);
        push_req(OP_LOOKUP, 31'd64);
        wait_drained();

        // oversize saturates to the full table
        write_table_size(7'd127);
        push_req(OP_LOOKUP, 31'd127);
        push_req(OP_INSERT, 31'h7fff_ffff);
        push_req(OP_LOOKUP, 31'd1);
        wait_drained();

        for (int p = 0; p < 9; p++)
        begin
            if (p == 3)
            begin
                send_idle_pct = 77;
                recv_idle_pct = 35;
            end
            else if (p == 6)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_table_size(sizes[p]);
            random_phase(PHASE_ITEMS);
        end

        repeat (200) @(posedge clk);
        if (status_due_q.size() != 0)
            report_mismatch($sformatf("%0d status beats never arrived", status_due_q.size()));
        $display("Checked %0d status beats from %0d items over %0d table size settings.",
                 results_seen, items_accepted, size_settings);
        $display("Outcomes: inserted %0d, present %0d, full %0d, found %0d, missing %0d.",
                 status_hits[ST_INSERTED], status_hits[ST_PRESENT], status_hits[ST_FULL],
                 status_hits[ST_FOUND], status_hits[ST_MISSING]);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
